### rtl/sfd_pkg.sv
package sfd_pkg;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  localparam logic [7:0] PreambleFirst  = 8'h55;
  localparam logic [7:0] PreambleSecond = 8'hAA;

  localparam logic [15:0] MaxLengthReset = 16'd260;
  localparam logic [7:0]  VersionAReset  = 8'h00;
  localparam logic [7:0]  VersionBReset  = 8'h03;

  // Register indexes, taken from paddr[3:2]
  localparam logic [1:0] RegMaxLength = 2'd0;
  localparam logic [1:0] RegVersionA  = 2'd1;
  localparam logic [1:0] RegVersionB  = 2'd2;

  // Result kinds
  localparam logic [1:0] KindPayload = 2'd0;
  localparam logic [1:0] KindSumGood = 2'd1;
  localparam logic [1:0] KindSumBad  = 2'd2;

  typedef struct packed {
    logic [15:0] max_length;
    logic [7:0]  version_a;
    logic [7:0]  version_b;
  } cfg_t;

endpackage

### rtl/sfd_cfg_regs.sv
module sfd_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfd_pkg::AddrWidth-1:0] paddr,
  input  logic [sfd_pkg::DataWidth-1:0] pwdata,
  output logic [sfd_pkg::DataWidth-1:0] prdata,
  output logic                         pready,
  output sfd_pkg::cfg_t                cfg_o
);
  import sfd_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegMaxLength: cfg_d.max_length = pwdata[15:0];
        RegVersionA:  cfg_d.version_a  = pwdata[7:0];
        RegVersionB:  cfg_d.version_b  = pwdata[7:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_length <= MaxLengthReset;
      cfg_q.version_a  <= VersionAReset;
      cfg_q.version_b  <= VersionBReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegMaxLength: prdata = {16'd0, cfg_q.max_length};
      RegVersionA:  prdata = {24'd0, cfg_q.version_a};
      RegVersionB:  prdata = {24'd0, cfg_q.version_b};
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/sfd_parser.sv
module sfd_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sfd_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    serial_byte_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [1:0]    kind_o,
  output logic [7:0]    data_byte_o,
  output logic [15:0]   byte_index_o,
  output logic [7:0]    command_o,
  output logic [7:0]    version_o,
  output logic [15:0]   length_o,
  output logic          version_ok_o,
  output logic          frame_end_o
);
  import sfd_pkg::*;

  localparam logic [2:0] PhHunt1 = 3'd0;
  localparam logic [2:0] PhHunt2 = 3'd1;
  localparam logic [2:0] PhVer   = 3'd2;
  localparam logic [2:0] PhCmd   = 3'd3;
  localparam logic [2:0] PhLenH  = 3'd4;
  localparam logic [2:0] PhLenL  = 3'd5;
  localparam logic [2:0] PhData  = 3'd6;
  localparam logic [2:0] PhSum   = 3'd7;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  ver_q, ver_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] cnt_inc;
  logic [15:0] len_full;

  logic        accept;
  logic        emit;
  logic [1:0]  kind_new;
  logic [15:0] index_new;
  logic        ver_ok;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  kind_q;
  logic [7:0]  data_q;
  logic [15:0] index_q;
  logic [7:0]  out_cmd_q;
  logic [7:0]  out_ver_q;
  logic [15:0] out_len_q;
  logic        ver_ok_q;
  logic        end_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign cnt_inc    = cnt_q + 16'd1;
  assign len_full   = {len_q[15:8], serial_byte_i};
  assign ver_ok     = (ver_q == cfg_i.version_a) || (ver_q == cfg_i.version_b);

  always_comb begin
    phase_d   = phase_q;
    sum_d     = sum_q;
    ver_d     = ver_q;
    cmd_d     = cmd_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    emit      = 1'b0;
    kind_new  = KindPayload;
    index_new = cnt_q;
    unique case (phase_q)
      PhHunt1: begin
        if (serial_byte_i == PreambleFirst) begin
          sum_d   = serial_byte_i;
          phase_d = PhHunt2;
        end
      end
      PhHunt2: begin
        if (serial_byte_i == PreambleSecond) begin
          sum_d   = sum_q + serial_byte_i;
          phase_d = PhVer;
        end else if (serial_byte_i != PreambleFirst) begin
          phase_d = PhHunt1;
        end
      end
      PhVer: begin
        ver_d   = serial_byte_i;
        sum_d   = sum_q + serial_byte_i;
        phase_d = PhCmd;
      end
      PhCmd: begin
        cmd_d   = serial_byte_i;
        sum_d   = sum_q + serial_byte_i;
        phase_d = PhLenH;
      end
      PhLenH: begin
        len_d   = {serial_byte_i, 8'd0};
        sum_d   = sum_q + serial_byte_i;
        phase_d = PhLenL;
      end
      PhLenL: begin
        len_d = len_full;
        sum_d = sum_q + serial_byte_i;
        cnt_d = '0;
        if (len_full > cfg_i.max_length) begin
          phase_d = PhHunt1;
        end else if (len_full == 16'd0) begin
          phase_d = PhSum;
        end else begin
          phase_d = PhData;
        end
      end
      PhData: begin
        emit  = 1'b1;
        sum_d = sum_q + serial_byte_i;
        cnt_d = cnt_inc;
        if (cnt_inc >= len_q) begin
          phase_d = PhSum;
        end
      end
      PhSum: begin
        emit      = 1'b1;
        kind_new  = (serial_byte_i == sum_q) ? KindSumGood : KindSumBad;
        index_new = '0;
        phase_d   = PhHunt1;
      end
      default: phase_d = PhHunt1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt1;
      sum_q   <= '0;
      ver_q   <= '0;
      cmd_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      ver_q   <= ver_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (!out_valid_q || !out_stall_i) begin
      out_valid_d = accept && emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      kind_q    <= kind_new;
      data_q    <= serial_byte_i;
      index_q   <= index_new;
      out_cmd_q <= cmd_q;
      out_ver_q <= ver_q;
      out_len_q <= len_q;
      ver_ok_q  <= ver_ok;
      end_q     <= (phase_q == PhSum);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign data_byte_o  = data_q;
  assign byte_index_o = index_q;
  assign command_o    = out_cmd_q;
  assign version_o    = out_ver_q;
  assign length_o     = out_len_q;
  assign version_ok_o = ver_ok_q;
  assign frame_end_o  = end_q;

endmodule

### rtl/serial_frame_deframer.sv
// An accepted payload or checksum byte reaches the output register as a result beat in the next cycle.
// Throughput: one input beat per cycle while not stalled; the output register refills in the cycle it drains.
// Input stalls only while a result waits in the output register and the sink stalls.
// Reset (rst_ni low, asynchronous): parser hunts for the first preamble byte, sums and
// header fields clear, output register empties, and the configuration registers return
// to max_length 260, accepted versions 0x00 and 0x03.
module serial_frame_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfd_pkg::AddrWidth-1:0] paddr,
  input  logic [sfd_pkg::DataWidth-1:0] pwdata,
  output logic [sfd_pkg::DataWidth-1:0] prdata,
  output logic                          pready,
  // received bytes
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    serial_byte_i,
  // result beats
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic [7:0]                    data_byte_o,
  output logic [15:0]                   byte_index_o,
  output logic [7:0]                    command_o,
  output logic [7:0]                    version_o,
  output logic [15:0]                   length_o,
  output logic                          version_ok_o,
  output logic                          frame_end_o
);
  import sfd_pkg::*;

  // Live register values; the user must write them only while the parser is idle, the block does not enforce it.
  cfg_t cfg;

  // Register file: max_length at 0x0, accepted_version_a at 0x4,
  // accepted_version_b at 0x8. Writes land on the access phase.
  sfd_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Parser: the phase register and frame header fields advance on each
  // accepted beat; payload bytes and the checksum verdict go to the output
  // register. Frames over max_length are dropped without any result beat.
  sfd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .serial_byte_i (serial_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .data_byte_o   (data_byte_o),
    .byte_index_o  (byte_index_o),
    .command_o     (command_o),
    .version_o     (version_o),
    .length_o      (length_o),
    .version_ok_o  (version_ok_o),
    .frame_end_o   (frame_end_o)
  );

endmodule

### rtl/sfd_checker.sv
module sfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [7:0]  data_byte_o,
  input logic [15:0] byte_index_o,
  input logic [15:0] length_o,
  input logic        frame_end_o
);
  import sfd_pkg::*;

  // Input stalls only behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  // Frame end flag agrees with the result kind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_end_o == (kind_o != KindPayload)))
    else $error("frame_end and kind disagree");

  // Payload index stays inside the declared length; frame end reports index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_end_o ? (byte_index_o == 16'd0) : (byte_index_o < length_o)))
    else $error("byte_index out of range");

  // Stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_byte_o) && $stable(kind_o))
    else $error("stalled result changed");

endmodule

bind serial_frame_deframer sfd_checker u_sfd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .kind_o       (kind_o),
  .data_byte_o  (data_byte_o),
  .byte_index_o (byte_index_o),
  .length_o     (length_o),
  .frame_end_o  (frame_end_o)
);

### verif/serial_frame_deframer_tb.sv
module serial_frame_deframer_tb;

  import sfd_pkg::*;

  // Spare register slot: writes there must leave every register untouched
  localparam logic [1:0] RegSpare = 2'd3;
  // Cycles with no beat on either channel before the run is declared hung
  localparam int QuietLimit = 200;
  // Random bytes per configuration phase, and the number of such phases
  localparam int PhaseBytes = 100;
  localparam int NumPhases = 8;

  // Parser position, one step per received byte
  typedef enum logic [2:0] {
    SeekFirst,
    SeekSecond,
    TakeVersion,
    TakeCommand,
    TakeLenHigh,
    TakeLenLow,
    TakePayload,
    TakeChecksum
  } parse_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [7:0]  command;
    logic [7:0]  version;
    logic [15:0] length;
    logic        version_ok;
    logic        frame_end;
  } frame_beat_t;

  typedef logic [7:0] octet_q_t[$];

  function automatic string beat_text(frame_beat_t b);
    return $sformatf("kind %0d data %02h index %0d cmd %02h ver %02h len %0d ok %0b end %0b",
                     b.kind, b.data_byte, b.byte_index, b.command, b.version, b.length,
                     b.version_ok, b.frame_end);
  endfunction

  // Tracks the parser byte by byte and holds the beats it must produce.
  class frame_tracker;
    logic [15:0]  max_len;
    logic [7:0]   ver_a;
    logic [7:0]   ver_b;
    parse_e       state;
    logic [7:0]   sum;
    logic [7:0]   ver;
    logic [7:0]   cmd;
    logic [15:0]  len;
    logic [15:0]  count;
    frame_beat_t  pending_beats[$];
    int           fault_count;

    function new();
      max_len = MaxLengthReset;
      ver_a = VersionAReset;
      ver_b = VersionBReset;
      state = SeekFirst;
      sum = '0;
      ver = '0;
      cmd = '0;
      len = '0;
      count = '0;
      fault_count = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        RegMaxLength: max_len = value[15:0];
        RegVersionA:  ver_a = value[7:0];
        RegVersionB:  ver_b = value[7:0];
        default: ;
      endcase
    endfunction

    function void push_beat(logic [1:0] kind, logic [7:0] data, logic [15:0] idx,
                            logic fin);
      frame_beat_t b;
      b.kind = kind;
      b.data_byte = data;
      b.byte_index = idx;
      b.command = cmd;
      b.version = ver;
      b.length = len;
      b.version_ok = (ver == ver_a) || (ver == ver_b);
      b.frame_end = fin;
      pending_beats.push_back(b);
    endfunction

    function void note_byte(logic [7:0] b);
      case (state)
        SeekFirst: begin
          if (b == PreambleFirst) begin
            sum = b;
            state = SeekSecond;
          end
        end
        SeekSecond: begin
          // a repeated first preamble byte keeps us waiting, sum unchanged
          if (b == PreambleSecond) begin
            sum = sum + b;
            state = TakeVersion;
          end else if (b != PreambleFirst) begin
            state = SeekFirst;
          end
        end
        TakeVersion: begin
          ver = b;
          sum = sum + b;
          state = TakeCommand;
        end
        TakeCommand: begin
          cmd = b;
          sum = sum + b;
          state = TakeLenHigh;
        end
        TakeLenHigh: begin
          len = {b, 8'h00};
          sum = sum + b;
          state = TakeLenLow;
        end
        TakeLenLow: begin
          len = {len[15:8], b};
          sum = sum + b;
          count = '0;
          if (len > max_len) state = SeekFirst;
          else if (len == 16'd0) state = TakeChecksum;
          else state = TakePayload;
        end
        TakePayload: begin
          push_beat(KindPayload, b, count, 1'b0);
          sum = sum + b;
          count = count + 16'd1;
          if (count >= len) state = TakeChecksum;
        end
        default: begin
          push_beat((b == sum) ? KindSumGood : KindSumBad, b, 16'd0, 1'b1);
          state = SeekFirst;
        end
      endcase
    endfunction

    function void check_result(frame_beat_t seen);
      frame_beat_t want;
      if (pending_beats.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result beat: %s", beat_text(seen));
      end else begin
        want = pending_beats.pop_front();
        if (seen !== want) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("result mismatch");
            $display("  expected %s", beat_text(want));
            $display("  actual   %s", beat_text(seen));
          end
        end
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [7:0]           serial_byte_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [1:0]           kind_o;
  logic [7:0]           data_byte_o;
  logic [15:0]          byte_index_o;
  logic [7:0]           command_o;
  logic [7:0]           version_o;
  logic [15:0]          length_o;
  logic                 version_ok_o;
  logic                 frame_end_o;

  frame_tracker tracker;
  octet_q_t     tx_bytes;
  // Settings as last written, so generated frames know which lengths get dropped
  logic [15:0]  cur_max_len = MaxLengthReset;
  logic [7:0]   cur_ver_a = VersionAReset;
  logic [7:0]   cur_ver_b = VersionBReset;
  bit           src_idle;
  bit           sink_idle;
  int           hold_cycles;
  int           quiet_cycles;

  serial_frame_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .serial_byte_i (serial_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .data_byte_o   (data_byte_o),
    .byte_index_o  (byte_index_o),
    .command_o     (command_o),
    .version_o     (version_o),
    .length_o      (length_o),
    .version_ok_o  (version_ok_o),
    .frame_end_o   (frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result sink: take every beat offered, then hold stall for a drawn number of
  // cycles. The countdown runs whether or not a beat waits, so stalls land on
  // every phase of the block's work.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        tracker.check_result({kind_o, data_byte_o, byte_index_o, command_o, version_o,
                              length_o, version_ok_o, frame_end_o});
        hold_cycles = sink_idle ? $urandom_range(0, 7) : 0;
      end else if (hold_cycles > 0) begin
        hold_cycles--;
      end
      out_stall_i <= (hold_cycles > 0);
    end
  end

  // Watchdog: a run that moves no beat for too long is hung
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Append one frame. A length over the current maximum gets its header only,
  // since the parser drops the frame right after the length bytes.
  function automatic void add_frame(logic [7:0] ver, logic [7:0] cmd, logic [15:0] len,
                                    bit good_sum, int lead_first);
    logic [7:0] sum;
    logic [7:0] b;
    octet_q_t   header;
    header = '{PreambleFirst, PreambleSecond, ver, cmd, len[15:8], len[7:0]};
    sum = '0;
    repeat (lead_first) tx_bytes.push_back(PreambleFirst);
    foreach (header[i]) begin
      tx_bytes.push_back(header[i]);
      sum = sum + header[i];
    end
    if (len <= cur_max_len) begin
      for (int i = 0; i < int'(len); i++) begin
        b = 8'($urandom);
        tx_bytes.push_back(b);
        sum = sum + b;
      end
      tx_bytes.push_back(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
    end
  endfunction

  // Mostly well-formed frames with random content; the rest line noise and
  // preambles broken off after the first byte.
  function automatic void add_random_sequence();
    int          pick;
    int          r;
    logic [7:0]  ver;
    logic [7:0]  b;
    logic [15:0] len;
    logic [15:0] cap;
    pick = $urandom_range(0, 9);
    if (pick < 8) begin
      case ($urandom_range(0, 2))
        0: ver = cur_ver_a;
        1: ver = cur_ver_b;
        default: ver = 8'($urandom);
      endcase
      cap = (cur_max_len < 16'd12) ? cur_max_len : 16'd12;
      r = $urandom_range(0, 9);
      if (r < 6) len = 16'($urandom_range(0, int'(cap)));
      else if (r == 6 && cur_max_len <= 16'd40) len = cur_max_len;
      else if (cur_max_len < 16'hFFFF)
        len = (r < 8) ? cur_max_len + 16'd1 : 16'($urandom_range(int'(cur_max_len) + 1, 65535));
      else len = 16'($urandom_range(0, 12));
      add_frame(ver, 8'($urandom), len, $urandom_range(0, 3) != 0,
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
    end else if (pick == 8) begin
      repeat ($urandom_range(1, 3)) tx_bytes.push_back(8'($urandom));
    end else begin
      b = 8'($urandom);
      if (b == PreambleFirst || b == PreambleSecond) b = 8'h00;
      tx_bytes.push_back(PreambleFirst);
      tx_bytes.push_back(b);
    end
  endfunction

  // Drive the queued bytes, one beat each, with a drawn gap before every beat.
  // Valid stays high across back-to-back beats; the payload only moves once
  // the current beat has gone.
  task automatic send_bytes();
    int gap;
    while (tx_bytes.size() != 0) begin
      gap = src_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      serial_byte_i <= tx_bytes[0];
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      tracker.note_byte(tx_bytes.pop_front());
    end
  endtask

  // Drop valid, wait for every expected beat, then let the output stage empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.pending_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_register(idx, value);
  endtask

  // Settings per phase: zero and full-scale maximum lengths, a single byte, a
  // small one, the reset value and one below full scale; then random small ones.
  // Upper data bits carry junk to show the registers keep their own width only.
  task automatic configure(input int phase_idx);
    logic [15:0] ml;
    logic [7:0]  va;
    logic [7:0]  vb;
    va = 8'($urandom);
    vb = 8'($urandom);
    case (phase_idx)
      0: begin
        ml = 16'd0;
        va = 8'hFF;
        vb = 8'h00;
      end
      1: begin
        ml = 16'hFFFF;
        vb = va;
      end
      2: ml = 16'd1;
      3: ml = 16'd6;
      4: begin
        ml = MaxLengthReset;
        va = VersionAReset;
        vb = VersionBReset;
      end
      5: ml = 16'hFFFE;
      default: ml = 16'($urandom_range(2, 30));
    endcase
    write_reg(RegMaxLength, {16'($urandom), ml});
    write_reg(RegVersionA, {24'($urandom), va});
    write_reg(RegVersionB, {24'($urandom), vb});
    if (phase_idx % 3 == 1) write_reg(RegSpare, $urandom);
    cur_max_len = ml;
    cur_ver_a = va;
    cur_ver_b = vb;
  endtask

  initial begin
    tracker = new();
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid_i <= 1'b0;
    serial_byte_i <= '0;
    out_stall_i <= 1'b0;
    hold_cycles = 0;
    quiet_cycles <= 0;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats under reset settings: all-zero and all-one noise, a frame
    // behind a repeated first preamble byte with the second accepted version,
    // a preamble broken after its first byte, a length one over the reset
    // maximum, and a zero-length frame with an unknown version and bad sum.
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    add_frame(VersionBReset, 8'h7E, 16'd1, 1'b1, 1);
    tx_bytes.push_back(PreambleFirst);
    tx_bytes.push_back(8'h00);
    add_frame(VersionAReset, 8'hFF, MaxLengthReset + 16'd1, 1'b1, 0);
    add_frame(8'h80, 8'h00, 16'd0, 1'b0, 0);
    send_bytes();

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      configure(p);
      // one phase runs flat out on both sides
      src_idle = (p != 3) && ($urandom_range(0, 3) != 0);
      sink_idle = (p != 3) && ($urandom_range(0, 3) != 0);
      while (tx_bytes.size() < PhaseBytes) add_random_sequence();
      send_bytes();
    end
    settle();

    if (tracker.fault_count == 0 && tracker.pending_beats.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
